[src/ipv4_header_parse_check_core_assert.svh]
// Assertion macros for the IPv4 header parser RTL.
// Included by ihpc_outq, which checks its own logic; no other dependency.
`ifndef IPV4_HEADER_PARSE_CHECK_CORE_ASSERT_SVH
`define IPV4_HEADER_PARSE_CHECK_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define IHPC_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A cause in one cycle and its required effect in the next cycle.
`define IHPC_CHECK_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

[src/ihpc_pkg.sv]
// Shared types, constants and helper functions for the IPv4 header parser.
// Used by ihpc_parse, ihpc_outq and ipv4_header_parse_check_core.
`default_nettype none

package ihpc_pkg;

  localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;
  localparam logic [5:0]  MIN_FRAME_RESET = 6'd20;

  // Status codes of a summary item.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BELOW_MIN = 2'd1;
  localparam logic [1:0] STATUS_SHORT_HDR = 2'd2;

  // Item kinds, carried on tuser.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_MIN_FRAME = 1'b0;

  localparam int TDATA_W    = 144;
  localparam int ITEM_W     = 137;
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic        kind;
    logic [15:0] payload_length;
    logic [31:0] destination_address;
    logic [31:0] source_address;
    logic        checksum_ok;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [7:0]  time_to_live;
    logic [7:0]  service_type;
    logic [5:0]  header_bytes;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
  } res_t;

  // Up to two result items produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  // 16-bit ones' complement addition with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Everything but the kind, last field (payload_byte) in the lowest bits, zero padded.
  function automatic logic [TDATA_W-1:0] pack_tdata(input res_t r);
    logic [ITEM_W-1:0] body;
    body = {r.payload_length, r.destination_address, r.source_address, r.checksum_ok,
            r.total_length, r.protocol_number, r.time_to_live, r.service_type,
            r.header_bytes, r.status, r.payload_byte};
    return {{(TDATA_W-ITEM_W){1'b0}}, body};
  endfunction

endpackage

`default_nettype wire

[src/ihpc_parse.sv]
// Per-byte header parser: field capture, ones' complement sum and result forming.
// Depends on ihpc_pkg for the result types and the checksum helper.
`default_nettype none

module ihpc_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [5:0]     min_frame_bytes,
  input  wire logic           accept,
  input  wire logic [7:0]     frame_byte,
  input  wire logic           frame_last,
  output ihpc_pkg::push_t     push
);

  logic [15:0] pos_r,  pos_nxt;
  logic [5:0]  hlen_r, hlen_nxt;
  logic [15:0] sum_r,  sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [7:0]  tos_r,  tos_nxt;
  logic [7:0]  ttl_r,  ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] len_r,  len_nxt;
  logic [31:0] src_r,  src_nxt;
  logic [31:0] dst_r,  dst_nxt;

  logic [15:0]     flen;
  logic            in_hdr;
  logic            hdr_done;
  ihpc_pkg::res_t  pay_item;
  ihpc_pkg::res_t  sum_item;

  always_comb begin
    // Byte 0 sets the header length and is judged against it at once.
    hlen_nxt = (pos_r == 16'd0) ? {frame_byte[3:0], 2'b00} : hlen_r;
    in_hdr   = pos_r < {10'd0, hlen_nxt};

    hold_nxt = hold_r;
    sum_nxt  = sum_r;
    if (in_hdr) begin
      if (!pos_r[0]) begin
        hold_nxt = frame_byte;
      end else begin
        sum_nxt = ihpc_pkg::ones_add(sum_r, {hold_r, frame_byte});
      end
    end

    tos_nxt   = (pos_r == 16'd1) ? frame_byte : tos_r;
    ttl_nxt   = (pos_r == 16'd8) ? frame_byte : ttl_r;
    proto_nxt = (pos_r == 16'd9) ? frame_byte : proto_r;
    len_nxt   = (pos_r == 16'd2 || pos_r == 16'd3) ? {len_r[7:0], frame_byte} : len_r;
    src_nxt   = (pos_r >= 16'd12 && pos_r <= 16'd15) ? {src_r[23:0], frame_byte} : src_r;
    dst_nxt   = (pos_r >= 16'd16 && pos_r <= 16'd19) ? {dst_r[23:0], frame_byte} : dst_r;

    flen     = (pos_r == ihpc_pkg::MAX_FRAME_BYTES) ? ihpc_pkg::MAX_FRAME_BYTES
                                                    : pos_r + 16'd1;
    pos_nxt  = flen;
    hdr_done = flen >= {10'd0, hlen_nxt};

    pay_item              = '0;
    pay_item.kind         = ihpc_pkg::KIND_PAYLOAD;
    pay_item.payload_byte = frame_byte;

    sum_item      = '0;
    sum_item.kind = ihpc_pkg::KIND_SUMMARY;
    priority if (flen < {10'd0, min_frame_bytes}) begin
      sum_item.status = ihpc_pkg::STATUS_BELOW_MIN;
    end else if (!hdr_done) begin
      sum_item.status = ihpc_pkg::STATUS_SHORT_HDR;
    end else begin
      sum_item.status = ihpc_pkg::STATUS_OK;
    end
    sum_item.header_bytes        = hlen_nxt;
    sum_item.service_type        = tos_nxt;
    sum_item.time_to_live        = ttl_nxt;
    sum_item.protocol_number     = proto_nxt;
    sum_item.total_length        = len_nxt;
    sum_item.checksum_ok         = hdr_done && (sum_nxt == 16'hFFFF);
    sum_item.source_address      = src_nxt;
    sum_item.destination_address = dst_nxt;
    sum_item.payload_length      = hdr_done ? (flen - {10'd0, hlen_nxt}) : 16'd0;

    // Payload goes out first; a summary on the last byte follows it.
    push.first  = in_hdr ? sum_item : pay_item;
    push.second = sum_item;
    if (!accept) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, !in_hdr} + {1'b0, frame_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && frame_last)) begin
      pos_r   <= '0;
      hlen_r  <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      tos_r   <= '0;
      ttl_r   <= '0;
      proto_r <= '0;
      len_r   <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      hlen_r  <= hlen_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      tos_r   <= tos_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      len_r   <= len_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

endmodule

`default_nettype wire

[src/ihpc_outq.sv]
// Four-entry result queue that takes up to two items per cycle and gives one per pop.
// Depends on ihpc_pkg and on the assertion macro header.
`default_nettype none
`include "ipv4_header_parse_check_core_assert.svh"

module ihpc_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ihpc_pkg::push_t push,
  output logic                 room,
  output logic                 head_valid,
  output ihpc_pkg::res_t       head,
  input  wire logic            pop
);

  ihpc_pkg::res_t ent_r [ihpc_pkg::OUTQ_DEPTH];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  assign head_valid = count_r != 3'd0;
  assign head       = ent_r[rptr_r];
  assign room       = count_r <= 3'd2;
  assign do_pop     = pop && head_valid;
  assign count_nxt  = count_r + {1'b0, push.count} - {2'b00, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + push.count;
      rptr_r  <= rptr_r + {1'b0, do_pop};
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      ent_r[wptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      ent_r[wptr_r + 2'd1] <= push.second;
    end
  end

  `IHPC_CHECK(a_count_bound, count_r <= 3'd4, "result queue count beyond depth")
  `IHPC_CHECK(a_no_overflow, push.count != 2'd2 || count_r <= 3'd2,
              "two results pushed without room")
  `IHPC_CHECK_NEXT(a_drain, do_pop && push.count == 2'd0,
                   count_r == $past(count_r) - 3'd1, "queue count lost a pop")
  `IHPC_CHECK_NEXT(a_fill, !do_pop && push.count == 2'd2,
                   count_r == $past(count_r) + 3'd2, "queue count lost a push")

endmodule

`default_nettype wire

[src/ipv4_header_parse_check_core.sv]
// Top level of the IPv4 header parser and checksum checker.
// Instantiates ihpc_parse and ihpc_outq; uses ihpc_pkg.
`default_nettype none

// The block takes an IPv4 frame one byte per transfer on the in_ stream, byte 0
// first, with in_tlast on the final byte, and accepts one byte every clock cycle
// whenever its four-entry result queue has room for two results. Each byte at or
// beyond the header length (IHL times four, taken from byte 0) is queued as
// a payload transfer on the out_ stream with out_tuser low. The last byte also
// produces a summary transfer with out_tuser high, right after any payload
// transfer of that byte, carrying status, header fields, checksum validity and
// the payload length; all per-frame state then clears for the next frame. Every
// result is registered in the result queue before it reaches the output. Since the
// output gives one transfer per cycle and a frame's last byte may yield two,
// the queue briefly holds in_tready low only when the downstream side stalls or
// frames with a zero header length, whose every byte is payload, arrive back to
// back; otherwise the rate is one byte per cycle. The minimum frame length
// register (reset 20) sits at APB byte address 0; the user must see that it is
// written only while no frame is in flight, which the block does not enforce.
module ipv4_header_parse_check_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input stream.
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [7:0] frame_byte
  input  wire logic                         in_tlast,   // frame_last
  // Result stream.
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [7:0] payload_byte, [9:8] status, [15:10] header_bytes, [23:16] service_type,
  // [31:24] time_to_live, [39:32] protocol_number, [55:40] total_length,
  // [56] checksum_ok, [88:57] source_address, [120:89] destination_address,
  // [136:121] payload_length, [143:137] zero
  output logic [ihpc_pkg::TDATA_W-1:0]      out_tdata,
  output logic                              out_tuser,  // kind
  // Configuration port.
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [2:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  logic [5:0]      min_frame_r;
  logic            in_accept;
  logic            room;
  ihpc_pkg::push_t push;
  ihpc_pkg::res_t  head;

  // The register is written in the access phase; pready never stalls.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ihpc_pkg::REG_MIN_FRAME) ? {26'd0, min_frame_r}
                                                                : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frame_r <= ihpc_pkg::MIN_FRAME_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == ihpc_pkg::REG_MIN_FRAME) begin
      min_frame_r <= cfg_pwdata[5:0];
    end
  end

  // A byte is taken only when the queue can absorb the two results it may cause.
  assign in_tready = room;
  assign in_accept = in_tvalid && in_tready;

  ihpc_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .min_frame_bytes (min_frame_r),
    .accept          (in_accept),
    .frame_byte      (in_tdata),
    .frame_last      (in_tlast),
    .push            (push)
  );

  ihpc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = ihpc_pkg::pack_tdata(head);
  assign out_tuser = head.kind;

endmodule

`default_nettype wire
